// ----- rtl/hrsp_pkg.sv -----
package hrsp_pkg;

  localparam int BODY_COUNT_BITS = 16;
  localparam int BODY_LEN_W      = 16;

  typedef logic [BODY_COUNT_BITS-1:0] body_count_t;
  typedef logic [BODY_LEN_W-1:0]      body_len_t;

  typedef enum logic [3:0] {
    PH_METHOD     = 4'd0,
    PH_PATH_FIRST = 4'd1,
    PH_PATH       = 4'd2,
    PH_QUERY      = 4'd3,
    PH_FRAG       = 4'd4,
    PH_VERSION    = 4'd5,
    PH_SKIP_LINE  = 4'd6,
    PH_HDR_NAME   = 4'd7,
    PH_HDR_GAP    = 4'd8,
    PH_HDR_VALUE  = 4'd9,
    PH_SKIP_END   = 4'd10,
    PH_BODY       = 4'd11,
    PH_ERROR      = 4'd12
  } phase_e;

  localparam logic [2:0] TOK_NONE    = 3'd0;
  localparam logic [2:0] TOK_PATH    = 3'd1;
  localparam logic [2:0] TOK_QKEY    = 3'd2;
  localparam logic [2:0] TOK_QVAL    = 3'd3;
  localparam logic [2:0] TOK_HNAME   = 3'd4;
  localparam logic [2:0] TOK_HVAL    = 3'd5;
  localparam logic [2:0] TOK_BODY    = 3'd6;
  localparam logic [2:0] TOK_VERSION = 3'd7;

  localparam logic [2:0] METH_NONE = 3'd0;

  localparam logic [1:0] ST_PARSING = 2'd0;
  localparam logic [1:0] ST_VALID   = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  localparam logic [1:0] ESC_IDLE = 2'd0;
  localparam logic [1:0] ESC_HIGH = 2'd1;
  localparam logic [1:0] ESC_LOW  = 2'd2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_QUEST = 8'h3F;

  localparam int          METH_NUM     = 6;
  localparam logic [3:0]  METH_MAX_LEN = 4'd7;
  localparam logic [3:0]  METH_OVER    = 4'd8;

  localparam logic [55:0] METH_TEXT [METH_NUM] = '{
    56'h474554, 56'h504F5354, 56'h505554,
    56'h44454C455445, 56'h4F5054494F4E53, 56'h5041544348
  };
  localparam logic [3:0] METH_LEN [METH_NUM] = '{4'd3, 4'd4, 4'd3, 4'd6, 4'd7, 4'd5};

  typedef struct packed {
    logic [2:0] token_class;
    logic       char_valid;
    logic [7:0] char_out;
    logic       token_done;
    logic [2:0] method_code;
    logic [1:0] parse_status;
    body_len_t  body_length;
  } result_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SP) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // 16 marks a non-digit
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd16;
    if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30;
    else if (c >= 8'h61 && c <= 8'h66) v = c - 8'h57;
    else if (c >= 8'h41 && c <= 8'h46) v = c - 8'h37;
    return v[4:0];
  endfunction

  // two escape characters under strtol base-16 rules, kept modulo 256
  function automatic logic [7:0] decode_pair(input logic [7:0] h, input logic [7:0] l);
    logic [4:0] hv;
    logic [4:0] lv;
    logic [7:0] r;
    hv = hex_val(h);
    lv = hex_val(l);
    r  = 8'd0;
    if (is_ws(h) || h == CH_PLUS) begin
      if (!lv[4]) r = {4'd0, lv[3:0]};
    end else if (h == CH_MINUS) begin
      if (!lv[4]) r = 8'd0 - {4'd0, lv[3:0]};
    end else if (!hv[4]) begin
      r = lv[4] ? {4'd0, hv[3:0]} : {hv[3:0], lv[3:0]};
    end
    return r;
  endfunction

  function automatic logic [2:0] method_match(input logic [55:0] text, input logic [3:0] len);
    logic [2:0] m;
    m = METH_NONE;
    for (int i = 0; i < METH_NUM; i++) begin
      if (len == METH_LEN[i] && text == METH_TEXT[i]) m = 3'(i + 1);
    end
    return m;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
  endfunction

endpackage

// ----- rtl/hrsp_if.sv -----
interface hrsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       final_byte;

  modport source (output valid, in_byte, final_byte, input ready);
  modport sink   (input valid, in_byte, final_byte, output ready);
endinterface

interface hrsp_out_if;
  logic                 valid;
  logic                 ready;
  logic [2:0]           token_class;
  logic                 char_valid;
  logic [7:0]           char_out;
  logic                 token_done;
  logic [2:0]           method_code;
  logic [1:0]           parse_status;
  hrsp_pkg::body_len_t  body_length;

  modport source (output valid, token_class, char_valid, char_out, token_done,
                  method_code, parse_status, body_length, input ready);
  modport sink   (input valid, token_class, char_valid, char_out, token_done,
                  method_code, parse_status, body_length, output ready);
endinterface

// ----- rtl/http_request_stream_parser_top.sv -----
// channel  dir  modport  word
// in_i     in   sink     in_byte, final_byte
// out_o    out  source   token_class, char_valid, char_out, token_done,
//                        method_code, parse_status, body_length
//
// one request byte per cycle while in_i.ready is high; each accepted byte gives one registered result word
// the per-byte decode sits between the parser state and a two-entry output buffer
// in_i.ready drops only while both output entries are held by a stalled sink
// asynchronous active-low reset returns the parser to the method phase, buffer empty
module http_request_stream_parser_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  hrsp_in_if.sink    in_i,
  hrsp_out_if.source out_o
);

  hrsp_pkg::result_t res, res_out;
  logic              step;
  logic              space;

  assign step       = in_i.valid && space;
  assign in_i.ready = space;

  hrsp_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .in_byte_i    (in_i.in_byte),
    .final_byte_i (in_i.final_byte),
    .result_o     (res)
  );

  hrsp_skid u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (step),
    .data_i  (res),
    .ready_o (space),
    .valid_o (out_o.valid),
    .pop_i   (out_o.ready),
    .data_o  (res_out)
  );

  assign out_o.token_class  = res_out.token_class;
  assign out_o.char_valid   = res_out.char_valid;
  assign out_o.char_out     = res_out.char_out;
  assign out_o.token_done   = res_out.token_done;
  assign out_o.method_code  = res_out.method_code;
  assign out_o.parse_status = res_out.parse_status;
  assign out_o.body_length  = res_out.body_length;

endmodule

// ----- rtl/hrsp_core.sv -----
module hrsp_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        in_byte_i,
  input  logic              final_byte_i,
  output hrsp_pkg::result_t result_o
);

  hrsp_pkg::phase_e      phase_q, phase_d;
  logic [55:0]           text_q, text_d;
  logic [3:0]            len_q, len_d;
  logic [2:0]            found_q, found_d;
  logic                  eq_q, eq_d;
  logic [1:0]            esc_q, esc_d;
  logic [7:0]            high_q, high_d;
  logic                  line_q, line_d;
  hrsp_pkg::body_count_t body_q, body_d;

  logic [7:0] b;
  logic       err;
  logic [2:0] match;

  assign b     = in_byte_i;
  assign match = hrsp_pkg::method_match(text_q, len_q);

  always_comb begin
    err = 1'b0;
    unique case (phase_q)
      hrsp_pkg::PH_METHOD:
        err = (b == hrsp_pkg::CH_NUL) || (b == hrsp_pkg::CH_SP && match == hrsp_pkg::METH_NONE);
      hrsp_pkg::PH_PATH_FIRST, hrsp_pkg::PH_PATH, hrsp_pkg::PH_QUERY, hrsp_pkg::PH_FRAG,
      hrsp_pkg::PH_VERSION, hrsp_pkg::PH_HDR_GAP, hrsp_pkg::PH_HDR_VALUE:
        err = (b == hrsp_pkg::CH_NUL);
      hrsp_pkg::PH_HDR_NAME:
        err = !(line_q && b == hrsp_pkg::CH_CR) &&
              (b == hrsp_pkg::CH_NUL || b == hrsp_pkg::CH_CR);
      default: err = 1'b0;
    endcase
  end

  // next state, before the end-of-request clear
  always_comb begin
    phase_d = phase_q;
    text_d  = text_q;
    len_d   = len_q;
    found_d = found_q;
    eq_d    = eq_q;
    esc_d   = esc_q;
    high_d  = high_q;
    line_d  = line_q;
    body_d  = body_q;
    unique case (phase_q)
      hrsp_pkg::PH_METHOD: begin
        if (b == hrsp_pkg::CH_SP) begin
          found_d = match;
          phase_d = hrsp_pkg::PH_PATH_FIRST;
        end else if (len_q < hrsp_pkg::METH_MAX_LEN) begin
          text_d = {text_q[47:0], b};
          len_d  = len_q + 4'd1;
        end else begin
          len_d = hrsp_pkg::METH_OVER;
        end
      end
      hrsp_pkg::PH_PATH_FIRST: phase_d = hrsp_pkg::PH_PATH;
      hrsp_pkg::PH_PATH: begin
        if (b == hrsp_pkg::CH_QUEST || b == hrsp_pkg::CH_HASH || b == hrsp_pkg::CH_SP) begin
          eq_d  = 1'b0;
          esc_d = hrsp_pkg::ESC_IDLE;
          if (b == hrsp_pkg::CH_QUEST) phase_d = hrsp_pkg::PH_QUERY;
          else if (b == hrsp_pkg::CH_HASH) phase_d = hrsp_pkg::PH_FRAG;
          else phase_d = hrsp_pkg::PH_VERSION;
        end
      end
      hrsp_pkg::PH_QUERY: begin
        if (b == hrsp_pkg::CH_SP || b == hrsp_pkg::CH_HASH || b == hrsp_pkg::CH_AMP) begin
          eq_d  = 1'b0;
          esc_d = hrsp_pkg::ESC_IDLE;
          if (b == hrsp_pkg::CH_SP) phase_d = hrsp_pkg::PH_VERSION;
          else if (b == hrsp_pkg::CH_HASH) phase_d = hrsp_pkg::PH_FRAG;
        end else if (!eq_q) begin
          if (b == hrsp_pkg::CH_EQ) eq_d = 1'b1;
        end else if (esc_q == hrsp_pkg::ESC_HIGH) begin
          high_d = b;
          esc_d  = hrsp_pkg::ESC_LOW;
        end else if (esc_q == hrsp_pkg::ESC_LOW) begin
          esc_d = hrsp_pkg::ESC_IDLE;
        end else if (b == hrsp_pkg::CH_PCT) begin
          esc_d = hrsp_pkg::ESC_HIGH;
        end else begin
          esc_d = hrsp_pkg::ESC_IDLE;
        end
      end
      hrsp_pkg::PH_FRAG:
        if (b == hrsp_pkg::CH_SP) phase_d = hrsp_pkg::PH_VERSION;
      hrsp_pkg::PH_VERSION:
        if (b == hrsp_pkg::CH_CR) phase_d = hrsp_pkg::PH_SKIP_LINE;
      hrsp_pkg::PH_SKIP_LINE: begin
        phase_d = hrsp_pkg::PH_HDR_NAME;
        line_d  = 1'b1;
      end
      hrsp_pkg::PH_HDR_NAME: begin
        line_d = 1'b0;
        if (line_q && b == hrsp_pkg::CH_CR) phase_d = hrsp_pkg::PH_SKIP_END;
        else if (b == hrsp_pkg::CH_COLON) phase_d = hrsp_pkg::PH_HDR_GAP;
      end
      hrsp_pkg::PH_HDR_GAP, hrsp_pkg::PH_HDR_VALUE: begin
        if (b == hrsp_pkg::CH_CR) phase_d = hrsp_pkg::PH_SKIP_LINE;
        else if (!(phase_q == hrsp_pkg::PH_HDR_GAP && hrsp_pkg::is_ws(b)))
          phase_d = hrsp_pkg::PH_HDR_VALUE;
      end
      hrsp_pkg::PH_SKIP_END: phase_d = hrsp_pkg::PH_BODY;
      hrsp_pkg::PH_BODY:
        if (body_q != '1) body_d = body_q + hrsp_pkg::body_count_t'(1);
      hrsp_pkg::PH_ERROR: phase_d = hrsp_pkg::PH_ERROR;
      default: phase_d = hrsp_pkg::PH_ERROR;
    endcase
    if (err) phase_d = hrsp_pkg::PH_ERROR;
  end

  // result word
  always_comb begin
    result_o = '0;
    unique case (phase_q)
      hrsp_pkg::PH_PATH_FIRST: begin
        result_o.token_class = hrsp_pkg::TOK_PATH;
        result_o.char_valid  = 1'b1;
        result_o.char_out    = b;
      end
      hrsp_pkg::PH_PATH: begin
        result_o.token_class = hrsp_pkg::TOK_PATH;
        if (b == hrsp_pkg::CH_QUEST || b == hrsp_pkg::CH_HASH || b == hrsp_pkg::CH_SP) begin
          result_o.token_done = 1'b1;
        end else begin
          result_o.char_valid = 1'b1;
          result_o.char_out   = b;
        end
      end
      hrsp_pkg::PH_QUERY: begin
        if (b == hrsp_pkg::CH_SP || b == hrsp_pkg::CH_HASH || b == hrsp_pkg::CH_AMP) begin
          result_o.token_class = eq_q ? hrsp_pkg::TOK_QVAL : hrsp_pkg::TOK_QKEY;
          result_o.token_done  = 1'b1;
        end else if (!eq_q) begin
          result_o.token_class = hrsp_pkg::TOK_QKEY;
          if (b == hrsp_pkg::CH_EQ) begin
            result_o.token_done = 1'b1;
          end else begin
            result_o.char_valid = 1'b1;
            result_o.char_out   = b;
          end
        end else if (esc_q == hrsp_pkg::ESC_LOW) begin
          result_o.token_class = hrsp_pkg::TOK_QVAL;
          result_o.char_valid  = 1'b1;
          result_o.char_out    = hrsp_pkg::decode_pair(high_q, b);
        end else if (esc_q != hrsp_pkg::ESC_HIGH && b != hrsp_pkg::CH_PCT) begin
          result_o.token_class = hrsp_pkg::TOK_QVAL;
          result_o.char_valid  = 1'b1;
          result_o.char_out    = (b == hrsp_pkg::CH_PLUS) ? hrsp_pkg::CH_SP : b;
        end
      end
      hrsp_pkg::PH_VERSION: begin
        result_o.token_class = hrsp_pkg::TOK_VERSION;
        if (b == hrsp_pkg::CH_CR) begin
          result_o.token_done = 1'b1;
        end else begin
          result_o.char_valid = 1'b1;
          result_o.char_out   = b;
        end
      end
      hrsp_pkg::PH_HDR_NAME: begin
        if (!(line_q && b == hrsp_pkg::CH_CR)) begin
          result_o.token_class = hrsp_pkg::TOK_HNAME;
          if (b == hrsp_pkg::CH_COLON) begin
            result_o.token_done = 1'b1;
          end else begin
            result_o.char_valid = 1'b1;
            result_o.char_out   = hrsp_pkg::to_lower(b);
          end
        end
      end
      hrsp_pkg::PH_HDR_GAP, hrsp_pkg::PH_HDR_VALUE: begin
        if (b == hrsp_pkg::CH_CR) begin
          result_o.token_class = hrsp_pkg::TOK_HVAL;
          result_o.token_done  = 1'b1;
        end else if (!(phase_q == hrsp_pkg::PH_HDR_GAP && hrsp_pkg::is_ws(b))) begin
          result_o.token_class = hrsp_pkg::TOK_HVAL;
          result_o.char_valid  = 1'b1;
          result_o.char_out    = b;
        end
      end
      hrsp_pkg::PH_BODY: begin
        result_o.token_class = hrsp_pkg::TOK_BODY;
        result_o.char_valid  = 1'b1;
        result_o.char_out    = b;
        result_o.token_done  = final_byte_i;
      end
      default: result_o.token_class = hrsp_pkg::TOK_NONE;
    endcase

    if (err) begin
      result_o.token_class = hrsp_pkg::TOK_NONE;
      result_o.char_valid  = 1'b0;
      result_o.char_out    = 8'd0;
      result_o.token_done  = 1'b0;
    end

    if (phase_d == hrsp_pkg::PH_ERROR) result_o.parse_status = hrsp_pkg::ST_INVALID;
    else if (final_byte_i)
      result_o.parse_status = (phase_d == hrsp_pkg::PH_BODY) ? hrsp_pkg::ST_VALID
                                                             : hrsp_pkg::ST_INVALID;
    else result_o.parse_status = hrsp_pkg::ST_PARSING;

    result_o.method_code = found_d;
    if (hrsp_pkg::BODY_COUNT_BITS > hrsp_pkg::BODY_LEN_W &&
        (body_d >> hrsp_pkg::BODY_LEN_W) != '0)
      result_o.body_length = '1;
    else
      result_o.body_length = hrsp_pkg::body_len_t'(body_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= hrsp_pkg::PH_METHOD;
      text_q  <= '0;
      len_q   <= '0;
      found_q <= hrsp_pkg::METH_NONE;
      eq_q    <= 1'b0;
      esc_q   <= hrsp_pkg::ESC_IDLE;
      high_q  <= '0;
      line_q  <= 1'b0;
      body_q  <= '0;
    end else if (step_i) begin
      if (final_byte_i) begin
        // last byte of a request: start the next one from scratch
        phase_q <= hrsp_pkg::PH_METHOD;
        text_q  <= '0;
        len_q   <= '0;
        found_q <= hrsp_pkg::METH_NONE;
        eq_q    <= 1'b0;
        esc_q   <= hrsp_pkg::ESC_IDLE;
        high_q  <= '0;
        line_q  <= 1'b0;
        body_q  <= '0;
      end else begin
        phase_q <= phase_d;
        text_q  <= text_d;
        len_q   <= len_d;
        found_q <= found_d;
        eq_q    <= eq_d;
        esc_q   <= esc_d;
        high_q  <= high_d;
        line_q  <= line_d;
        body_q  <= body_d;
      end
    end
  end

endmodule

// ----- rtl/hrsp_skid.sv -----
module hrsp_skid (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  hrsp_pkg::result_t data_i,
  output logic              ready_o,
  output logic              valid_o,
  input  logic              pop_i,
  output hrsp_pkg::result_t data_o
);

  logic              head_vld_q, skid_vld_q;
  hrsp_pkg::result_t head_q, skid_q;
  logic              pop;

  assign valid_o = head_vld_q;
  assign data_o  = head_q;
  assign ready_o = !skid_vld_q;
  assign pop     = head_vld_q && pop_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (pop) begin
        // skid is empty whenever a push comes in
        head_vld_q <= skid_vld_q || push_i;
        skid_vld_q <= 1'b0;
      end else if (push_i) begin
        if (head_vld_q) skid_vld_q <= 1'b1;
        else head_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_vld_q) head_q <= skid_q;
      else if (push_i) head_q <= data_i;
    end else if (push_i) begin
      if (head_vld_q) skid_q <= data_i;
      else head_q <= data_i;
    end
  end

endmodule

// ----- rtl/hrsp_checker.sv -----
module hrsp_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [2:0]          token_class_i,
  input logic                char_valid_i,
  input logic [7:0]          char_out_i,
  input logic                token_done_i,
  input logic [2:0]          method_code_i,
  input logic [1:0]          parse_status_i,
  input hrsp_pkg::body_len_t body_length_i
);

  // stalled word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(token_class_i) &&
      $stable(char_out_i) && $stable(char_valid_i) && $stable(token_done_i) &&
      $stable(parse_status_i) && $stable(method_code_i) && $stable(body_length_i))
    else $error("output word changed under stall");

  a_idle_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !char_valid_i |-> char_out_i == 8'd0)
    else $error("char_out set without char_valid");

  a_idle_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !char_valid_i && !token_done_i |-> token_class_i == hrsp_pkg::TOK_NONE)
    else $error("token class on an idle word");

  a_valid_method: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && parse_status_i == hrsp_pkg::ST_VALID |->
      method_code_i != hrsp_pkg::METH_NONE)
    else $error("complete request without a method");

  a_body_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && token_class_i == hrsp_pkg::TOK_BODY && token_done_i |->
      parse_status_i == hrsp_pkg::ST_VALID)
    else $error("body ended without a complete request");

endmodule

bind http_request_stream_parser_top hrsp_checker u_hrsp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .token_class_i  (out_o.token_class),
  .char_valid_i   (out_o.char_valid),
  .char_out_i     (out_o.char_out),
  .token_done_i   (out_o.token_done),
  .method_code_i  (out_o.method_code),
  .parse_status_i (out_o.parse_status),
  .body_length_i  (out_o.body_length)
);

// ----- test/tb.sv -----
`timescale 1ns / 100ps

module tb;

  localparam int CYCLE_LIMIT = 1_000_000;

  localparam string URL_POOL = "abcmxyzABMZ0189-._~/";
  localparam string HEX_POOL = "0123456789abcdefABCDEF0-+\tgz";

  logic clk;
  logic rst_n;

  hrsp_in_if  in_if ();
  hrsp_out_if out_if ();

  http_request_stream_parser_top i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  string verb_names [6] = '{"GET", "POST", "PUT", "DELETE", "OPTIONS", "PATCH"};

  // parser state as the block should hold it
  hrsp_pkg::phase_e      ph;
  logic [55:0]           verb_text;
  logic [3:0]            verb_len;
  logic [2:0]            verb_code;
  logic                  eq_seen;
  logic [1:0]            esc_step;
  logic [7:0]            esc_hi;
  logic                  line_start;
  hrsp_pkg::body_count_t body_cnt;

  hrsp_pkg::result_t predicted_words [$];
  logic [7:0]        req_bytes [$];

  int mismatch_count;
  int words_seen;
  int cycle_count;
  int sink_hold_cycles;
  bit idle_on;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic void clear_parser();
    ph         = hrsp_pkg::PH_METHOD;
    verb_text  = '0;
    verb_len   = '0;
    verb_code  = hrsp_pkg::METH_NONE;
    eq_seen    = 1'b0;
    esc_step   = hrsp_pkg::ESC_IDLE;
    esc_hi     = '0;
    line_start = 1'b0;
    body_cnt   = '0;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == hrsp_pkg::CH_SP || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // -1 when the character is no hex digit
  function automatic int hex_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  function automatic hrsp_pkg::result_t char_word(input logic [2:0] cls, input logic [7:0] c);
    hrsp_pkg::result_t w;
    w = '0;
    w.token_class = cls;
    w.char_valid  = 1'b1;
    w.char_out    = c;
    return w;
  endfunction

  function automatic hrsp_pkg::result_t end_word(input logic [2:0] cls);
    hrsp_pkg::result_t w;
    w = '0;
    w.token_class = cls;
    w.token_done  = 1'b1;
    return w;
  endfunction

  function automatic hrsp_pkg::result_t predict_byte(input logic [7:0] b, input logic fin);
    hrsp_pkg::result_t r;
    logic              bad;
    int                i;
    int                k;
    int                dh;
    int                dl;
    logic [7:0]        dec;
    logic [55:0]       name_bits;
    string             nm;
    r   = '0;
    bad = 1'b0;
    case (ph)
      hrsp_pkg::PH_METHOD: begin
        if (b == hrsp_pkg::CH_NUL) bad = 1'b1;
        else if (b == hrsp_pkg::CH_SP) begin
          for (i = 0; i < 6; i++) begin
            nm = verb_names[i];
            name_bits = '0;
            for (k = 0; k < nm.len(); k++) name_bits = {name_bits[47:0], nm[k]};
            if (verb_len == 4'(nm.len()) && verb_text == name_bits) verb_code = 3'(i + 1);
          end
          if (verb_code == hrsp_pkg::METH_NONE) bad = 1'b1;
          else ph = hrsp_pkg::PH_PATH_FIRST;
        end else if (verb_len < hrsp_pkg::METH_MAX_LEN) begin
          verb_text = {verb_text[47:0], b};
          verb_len++;
        end else begin
          verb_len = hrsp_pkg::METH_OVER;
        end
      end
      hrsp_pkg::PH_PATH_FIRST: begin
        if (b == hrsp_pkg::CH_NUL) bad = 1'b1;
        else begin
          r = char_word(hrsp_pkg::TOK_PATH, b);
          ph = hrsp_pkg::PH_PATH;
        end
      end
      hrsp_pkg::PH_PATH: begin
        if (b == hrsp_pkg::CH_NUL) bad = 1'b1;
        else if (b == hrsp_pkg::CH_QUEST || b == hrsp_pkg::CH_HASH || b == hrsp_pkg::CH_SP) begin
          r = end_word(hrsp_pkg::TOK_PATH);
          eq_seen = 1'b0;
          esc_step = hrsp_pkg::ESC_IDLE;
          ph = (b == hrsp_pkg::CH_QUEST) ? hrsp_pkg::PH_QUERY :
               (b == hrsp_pkg::CH_HASH)  ? hrsp_pkg::PH_FRAG  : hrsp_pkg::PH_VERSION;
        end else begin
          r = char_word(hrsp_pkg::TOK_PATH, b);
        end
      end
      hrsp_pkg::PH_QUERY: begin
        if (b == hrsp_pkg::CH_NUL) bad = 1'b1;
        else if (b == hrsp_pkg::CH_SP || b == hrsp_pkg::CH_HASH || b == hrsp_pkg::CH_AMP) begin
          r = end_word(eq_seen ? hrsp_pkg::TOK_QVAL : hrsp_pkg::TOK_QKEY);
          eq_seen = 1'b0;
          esc_step = hrsp_pkg::ESC_IDLE;
          if (b == hrsp_pkg::CH_SP) ph = hrsp_pkg::PH_VERSION;
          else if (b == hrsp_pkg::CH_HASH) ph = hrsp_pkg::PH_FRAG;
        end else if (!eq_seen) begin
          if (b == hrsp_pkg::CH_EQ) begin
            r = end_word(hrsp_pkg::TOK_QKEY);
            eq_seen = 1'b1;
          end else begin
            r = char_word(hrsp_pkg::TOK_QKEY, b);
          end
        end else if (esc_step == hrsp_pkg::ESC_HIGH) begin
          esc_hi = b;
          esc_step = hrsp_pkg::ESC_LOW;
        end else if (esc_step == hrsp_pkg::ESC_LOW) begin
          // two escape characters read as a base-16 number, sign and blank allowed first
          dh = hex_digit(esc_hi);
          dl = hex_digit(b);
          dec = 8'd0;
          if (is_blank(esc_hi) || esc_hi == hrsp_pkg::CH_PLUS) begin
            if (dl >= 0) dec = 8'(dl);
          end else if (esc_hi == hrsp_pkg::CH_MINUS) begin
            if (dl >= 0) dec = 8'(-dl);
          end else if (dh >= 0) begin
            dec = (dl >= 0) ? 8'(dh * 16 + dl) : 8'(dh);
          end
          r = char_word(hrsp_pkg::TOK_QVAL, dec);
          esc_step = hrsp_pkg::ESC_IDLE;
        end else if (b == hrsp_pkg::CH_PCT) begin
          esc_step = hrsp_pkg::ESC_HIGH;
        end else begin
          r = char_word(hrsp_pkg::TOK_QVAL, (b == hrsp_pkg::CH_PLUS) ? hrsp_pkg::CH_SP : b);
        end
      end
      hrsp_pkg::PH_FRAG: begin
        if (b == hrsp_pkg::CH_NUL) bad = 1'b1;
        else if (b == hrsp_pkg::CH_SP) ph = hrsp_pkg::PH_VERSION;
      end
      hrsp_pkg::PH_VERSION: begin
        if (b == hrsp_pkg::CH_NUL) bad = 1'b1;
        else if (b == hrsp_pkg::CH_CR) begin
          r = end_word(hrsp_pkg::TOK_VERSION);
          ph = hrsp_pkg::PH_SKIP_LINE;
        end else begin
          r = char_word(hrsp_pkg::TOK_VERSION, b);
        end
      end
      hrsp_pkg::PH_SKIP_LINE: begin
        ph = hrsp_pkg::PH_HDR_NAME;
        line_start = 1'b1;
      end
      hrsp_pkg::PH_HDR_NAME: begin
        if (line_start && b == hrsp_pkg::CH_CR) begin
          line_start = 1'b0;
          ph = hrsp_pkg::PH_SKIP_END;
        end else begin
          line_start = 1'b0;
          if (b == hrsp_pkg::CH_NUL || b == hrsp_pkg::CH_CR) bad = 1'b1;
          else if (b == hrsp_pkg::CH_COLON) begin
            r = end_word(hrsp_pkg::TOK_HNAME);
            ph = hrsp_pkg::PH_HDR_GAP;
          end else begin
            r = char_word(hrsp_pkg::TOK_HNAME, (b >= "A" && b <= "Z") ? (b | 8'h20) : b);
          end
        end
      end
      hrsp_pkg::PH_HDR_GAP, hrsp_pkg::PH_HDR_VALUE: begin
        if (b == hrsp_pkg::CH_NUL) bad = 1'b1;
        else if (b == hrsp_pkg::CH_CR) begin
          r = end_word(hrsp_pkg::TOK_HVAL);
          ph = hrsp_pkg::PH_SKIP_LINE;
        end else if (!(ph == hrsp_pkg::PH_HDR_GAP && is_blank(b))) begin
          r = char_word(hrsp_pkg::TOK_HVAL, b);
          ph = hrsp_pkg::PH_HDR_VALUE;
        end
      end
      hrsp_pkg::PH_SKIP_END: begin
        ph = hrsp_pkg::PH_BODY;
      end
      hrsp_pkg::PH_BODY: begin
        if (body_cnt != '1) body_cnt++;
        r = char_word(hrsp_pkg::TOK_BODY, b);
        r.token_done = fin;
      end
      default: begin
        ph = hrsp_pkg::PH_ERROR;
      end
    endcase
    if (bad) begin
      ph = hrsp_pkg::PH_ERROR;
      r = '0;
    end
    r.method_code = verb_code;
    if (ph == hrsp_pkg::PH_ERROR) r.parse_status = hrsp_pkg::ST_INVALID;
    else if (fin)
      r.parse_status = (ph == hrsp_pkg::PH_BODY) ? hrsp_pkg::ST_VALID : hrsp_pkg::ST_INVALID;
    else r.parse_status = hrsp_pkg::ST_PARSING;
    r.body_length = body_cnt;
    if (fin) clear_parser();
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 50) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic compare_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("word %0d %s: got %0h, wanted %0h",
                                words_seen, name, got, want));
  endtask

  always @(posedge clk) begin : check_words
    hrsp_pkg::result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (predicted_words.size() == 0) begin
        report_mismatch($sformatf("word %0d arrived with nothing outstanding", words_seen));
      end else begin
        want = predicted_words.pop_front();
        compare_field("token_class", 16'(out_if.token_class), 16'(want.token_class));
        compare_field("char_valid", 16'(out_if.char_valid), 16'(want.char_valid));
        compare_field("char_out", 16'(out_if.char_out), 16'(want.char_out));
        compare_field("token_done", 16'(out_if.token_done), 16'(want.token_done));
        compare_field("method_code", 16'(out_if.method_code), 16'(want.method_code));
        compare_field("parse_status", 16'(out_if.parse_status), 16'(want.parse_status));
        compare_field("body_length", 16'(out_if.body_length), 16'(want.body_length));
      end
      words_seen++;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  initial begin : drive_ready
    int gap_left;
    gap_left = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold_cycles > 0) begin
        sink_hold_cycles--;
        out_if.ready <= 1'b0;
      end else if (!idle_on) begin
        out_if.ready <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) gap_left = pick_gap();
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = (idle_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.in_byte    <= b;
    in_if.final_byte <= fin;
    do @(posedge clk); while (!in_if.ready);
    predicted_words.push_back(predict_byte(b, fin));
  endtask

  task automatic send_request();
    int k;
    for (k = 0; k < req_bytes.size(); k++) send_byte(req_bytes[k], k == req_bytes.size() - 1);
    req_bytes.delete();
  endtask

  task automatic add_text(input string s);
    int k;
    for (k = 0; k < s.len(); k++) req_bytes.push_back(s[k]);
  endtask

  function automatic logic [7:0] rand_pick(input string pool);
    return pool[$urandom_range(0, pool.len() - 1)];
  endfunction

  function automatic logic [7:0] path_byte();
    return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) : rand_pick(URL_POOL);
  endfunction

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (predicted_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_methods_and_tokens();
    idle_on = 1'b1;
    // full escape, cut escape at a separator, key alone, signed and blank escapes
    add_text("GET /a\377b?k=v+%41%4&x&y=%-5%+3%\t9%zz%5g#f x HTTP/1.1\r\n");
    add_text("Host:  Ex\r\nX-A:\tB\r\n\r\n");
    req_bytes.push_back(hrsp_pkg::CH_NUL);
    req_bytes.push_back(8'hFF);
    send_request();
    // odd first path bytes are still path characters
    add_text("POST ?q#x HTTP/1.0\r\nA:b\r\n\r\n");
    send_request();
    add_text("PUT  /p?a=1+2 V\r\n\r\n");
    send_request();
    add_text("DELETE #/ V\r\nK : v \r\n\r\nzz");
    send_request();
    add_text("OPTIONS * HTTP/1.1\r\nACCEPT-X:\r\n\r\n");
    send_request();
    add_text("PATCH /%41?%=1&= V\r\n\r\nb");
    send_request();
    wait_drained();
  endtask

  task automatic test_malformed_requests();
    idle_on = 1'b1;
    add_text("GETX / V\r\n\r\n");
    send_request();
    add_text("GE / V\r\n\r\n");
    send_request();
    // eight method characters never match
    add_text("OPTIONSX / V\r\n\r\n");
    send_request();
    add_text("GET /a");
    req_bytes.push_back(hrsp_pkg::CH_NUL);
    add_text("b V\r\n\r\n");
    send_request();
    add_text("GET / V\r\nBad\r\n\r\n");
    send_request();
    add_text("GET / V\r\nA:");
    req_bytes.push_back(hrsp_pkg::CH_NUL);
    add_text("\r\n\r\n");
    send_request();
    add_text("GET /?a=%");
    req_bytes.push_back(hrsp_pkg::CH_NUL);
    send_request();
    // the byte after a CR is skipped whatever it is
    add_text("GET / V\r");
    req_bytes.push_back(hrsp_pkg::CH_NUL);
    add_text("\r\n");
    send_request();
    req_bytes.push_back(hrsp_pkg::CH_NUL);
    send_request();
    wait_drained();
  endtask

  task automatic test_truncated_requests();
    idle_on = 1'b1;
    add_text("G");
    send_request();
    add_text("GET /x?y");
    send_request();
    add_text("POST / V\r\n\r");
    send_request();
    add_text("PUT / V\r\nA:b\r");
    send_request();
    wait_drained();
  endtask

  task automatic test_output_backpressure();
    int k;
    idle_on = 1'b0;
    sink_hold_cycles = 60;
    add_text("GET /full?a=b HTTP/1.1\r\nK:v\r\n\r\n");
    for (k = 0; k < 24; k++) req_bytes.push_back(8'($urandom_range(0, 255)));
    send_request();
    wait_drained();
  endtask

  task automatic test_random_requests();
    int good_bytes;
    int cnt;
    int sub;
    int k;
    int p;
    int mode;
    good_bytes = 0;
    while (good_bytes < 400) begin
      idle_on = ($urandom_range(0, 3) != 0);
      add_text(verb_names[$urandom_range(0, 5)]);
      req_bytes.push_back(hrsp_pkg::CH_SP);
      req_bytes.push_back(($urandom_range(0, 4) != 0) ? 8'h2F : path_byte());
      cnt = $urandom_range(0, 6);
      for (k = 0; k < cnt; k++) req_bytes.push_back(path_byte());
      if ($urandom_range(0, 1) == 1) begin
        req_bytes.push_back(hrsp_pkg::CH_QUEST);
        cnt = $urandom_range(1, 3);
        for (p = 0; p < cnt; p++) begin
          if (p > 0) req_bytes.push_back(hrsp_pkg::CH_AMP);
          sub = $urandom_range(0, 3);
          for (k = 0; k < sub; k++) req_bytes.push_back(rand_pick("abzAZ09-._~%+"));
          if ($urandom_range(0, 4) != 0) begin
            req_bytes.push_back(hrsp_pkg::CH_EQ);
            sub = $urandom_range(0, 4);
            for (k = 0; k < sub; k++) begin
              case ($urandom_range(0, 3))
                0: req_bytes.push_back(hrsp_pkg::CH_PLUS);
                1: begin
                  req_bytes.push_back(hrsp_pkg::CH_PCT);
                  req_bytes.push_back(rand_pick(HEX_POOL));
                  req_bytes.push_back(rand_pick(HEX_POOL));
                end
                default: req_bytes.push_back(rand_pick(URL_POOL));
              endcase
            end
            // escape left unfinished before the separator
            if ($urandom_range(0, 7) == 0) begin
              req_bytes.push_back(hrsp_pkg::CH_PCT);
              if ($urandom_range(0, 1) == 1) req_bytes.push_back(rand_pick(HEX_POOL));
            end
          end
        end
      end
      if ($urandom_range(0, 3) == 0) begin
        req_bytes.push_back(hrsp_pkg::CH_HASH);
        cnt = $urandom_range(0, 4);
        for (k = 0; k < cnt; k++) req_bytes.push_back(path_byte());
      end
      add_text(" HTTP/1.1\r\n");
      cnt = $urandom_range(0, 3);
      for (p = 0; p < cnt; p++) begin
        sub = $urandom_range(1, 6);
        for (k = 0; k < sub; k++) req_bytes.push_back(rand_pick("abyzABYZ-09_"));
        req_bytes.push_back(hrsp_pkg::CH_COLON);
        sub = $urandom_range(0, 2);
        for (k = 0; k < sub; k++) req_bytes.push_back(rand_pick(" \t"));
        sub = $urandom_range(0, 5);
        for (k = 0; k < sub; k++)
          req_bytes.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(14, 255))
                                                           : rand_pick(URL_POOL));
        add_text("\r\n");
      end
      add_text("\r\n");
      if ($urandom_range(0, 4) != 0) begin
        cnt = $urandom_range(1, 8);
        for (k = 0; k < cnt; k++) req_bytes.push_back(8'($urandom_range(0, 255)));
      end
      // a share of requests is cut short or damaged
      mode = $urandom_range(0, 9);
      if (mode == 0) begin
        cnt = $urandom_range(1, req_bytes.size());
        while (req_bytes.size() > cnt) void'(req_bytes.pop_back());
      end else if (mode == 1) begin
        req_bytes[$urandom_range(0, req_bytes.size() - 1)] = 8'($urandom_range(0, 255));
      end else if (mode == 2) begin
        req_bytes[$urandom_range(0, req_bytes.size() - 1)] = hrsp_pkg::CH_NUL;
      end else begin
        good_bytes += req_bytes.size();
      end
      send_request();
    end
    wait_drained();
  endtask

  initial begin
    in_if.valid      = 1'b0;
    in_if.in_byte    = 8'h00;
    in_if.final_byte = 1'b0;
    rst_n            = 1'b0;
    idle_on          = 1'b0;
    sink_hold_cycles = 0;
    mismatch_count   = 0;
    words_seen       = 0;
    cycle_count      = 0;
    clear_parser();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_methods_and_tokens();
    test_malformed_requests();
    test_truncated_requests();
    test_output_backpressure();
    test_random_requests();
    wait_drained();
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
